FILE: hdl/cpualu_pkg.sv
// Shared types for the 8-bit CPU ALU: operation codes, flag bit positions
// and the packed input and result words. No dependencies.
`default_nettype none

package cpualu_pkg;

    // Status byte bit positions
    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    // Constant ORed into A by ANE and LXA
    localparam logic [7:0] ANE_MAGIC = 8'hEE;

    typedef enum logic [5:0] {
        OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
        OP_SBC = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
        OP_BIT = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
        OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_LDA = 6'd15,
        OP_LDX = 6'd16, OP_LDY = 6'd17, OP_LAX = 6'd18, OP_INX = 6'd19,
        OP_DEX = 6'd20, OP_INY = 6'd21, OP_DEY = 6'd22, OP_TAX = 6'd23,
        OP_TAY = 6'd24, OP_TXA = 6'd25, OP_TYA = 6'd26, OP_TSX = 6'd27,
        OP_TXS = 6'd28, OP_ANC = 6'd29, OP_ALR = 6'd30, OP_ARR = 6'd31,
        OP_ANE = 6'd32, OP_LXA = 6'd33, OP_SBX = 6'd34, OP_LAS = 6'd35,
        OP_SLO = 6'd36, OP_RLA = 6'd37, OP_SRE = 6'd38, OP_RRA = 6'd39,
        OP_DCP = 6'd40, OP_ISB = 6'd41, OP_SAX = 6'd42
    } op_t;

    typedef struct packed {
        logic [5:0] mode;
        logic [7:0] operand_value;
        logic       to_accumulator;
        logic [7:0] acc_in;
        logic [7:0] x_in;
        logic [7:0] y_in;
        logic [7:0] sp_in;
        logic [7:0] flags_in;
    } in_t;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] sp_out;
        logic [7:0] flags_out;
        logic [7:0] mem_value;
        logic       mem_write;
    } out_t;

endpackage

`default_nettype wire

FILE: hdl/cpualu_core.sv
// Combinational ALU datapath: decodes one operation and computes registers,
// status byte and memory write-back. Depends on cpualu_pkg.
`default_nettype none

module cpualu_core
    import cpualu_pkg::*;
(
    input  in_t  op_word,
    output out_t res_word
);

    typedef struct packed {
        logic [7:0] sum;
        logic [7:0] p;
    } add_t;

    // Update N and Z from a result byte
    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[FL_Z] = (v == 8'h00);
        q[FL_N] = v[7];
        return q;
    endfunction

    // Binary add with carry in from P
    function automatic add_t add_carry(input logic [7:0] p, input logic [7:0] a,
                                       input logic [7:0] b);
        logic [8:0] sum9;
        add_t res;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, p[FL_C]};
        res.p = p;
        res.p[FL_C] = sum9[8];
        res.p[FL_V] = (a[7] ^ sum9[7]) & (b[7] ^ sum9[7]);
        res.p = set_nz(res.p, sum9[7:0]);
        res.sum = sum9[7:0];
        return res;
    endfunction

    // Compare: C is no borrow, N and Z from the difference
    function automatic logic [7:0] compare(input logic [7:0] p, input logic [7:0] r,
                                           input logic [7:0] m);
        logic [7:0] q;
        q = p;
        q[FL_C] = (r >= m);
        return set_nz(q, r - m);
    endfunction

    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_c;

    // Shift and rotate unit shared by ASL, LSR, ROL and ROR
    always_comb begin
        sh_src = op_word.to_accumulator ? op_word.acc_in : op_word.operand_value;
        case (op_word.mode)
            OP_ASL: begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            OP_ROL: begin
                sh_res = {sh_src[6:0], op_word.flags_in[FL_C]};
                sh_c   = sh_src[7];
            end
            OP_ROR: begin
                sh_res = {op_word.flags_in[FL_C], sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            default: begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
        endcase
    end

    // Decode and compute the new register set
    always_comb begin
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
        logic [7:0] m;
        logic [7:0] t;
        logic [7:0] wv;
        logic       wr;
        logic       cin;
        add_t       ad;

        a   = op_word.acc_in;
        x   = op_word.x_in;
        y   = op_word.y_in;
        s   = op_word.sp_in;
        p   = op_word.flags_in;
        m   = op_word.operand_value;
        cin = p[FL_C];
        t   = '0;
        wv  = '0;
        wr  = 1'b0;
        ad  = '0;

        unique case (op_word.mode) inside
            OP_ORA: begin a = a | m; p = set_nz(p, a); end
            OP_AND: begin a = a & m; p = set_nz(p, a); end
            OP_EOR: begin a = a ^ m; p = set_nz(p, a); end
            OP_ADC: begin
                ad = add_carry(p, a, m);
                a  = ad.sum;
                p  = ad.p;
            end
            OP_SBC: begin
                ad = add_carry(p, a, ~m);
                a  = ad.sum;
                p  = ad.p;
            end
            OP_CMP: p = compare(p, a, m);
            OP_CPX: p = compare(p, x, m);
            OP_CPY: p = compare(p, y, m);
            OP_BIT: begin
                p[FL_Z] = ((a & m) == 8'h00);
                p[FL_V] = m[6];
                p[FL_N] = m[7];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                p[FL_C] = sh_c;
                p = set_nz(p, sh_res);
                if (op_word.to_accumulator) begin
                    a = sh_res;
                end else begin
                    wv = sh_res;
                    wr = 1'b1;
                end
            end
            OP_INC: begin wv = m + 8'd1; wr = 1'b1; p = set_nz(p, wv); end
            OP_DEC: begin wv = m - 8'd1; wr = 1'b1; p = set_nz(p, wv); end
            OP_LDA: begin a = m; p = set_nz(p, a); end
            OP_LDX: begin x = m; p = set_nz(p, x); end
            OP_LDY: begin y = m; p = set_nz(p, y); end
            OP_LAX: begin a = m; x = m; p = set_nz(p, a); end
            OP_INX: begin x = x + 8'd1; p = set_nz(p, x); end
            OP_DEX: begin x = x - 8'd1; p = set_nz(p, x); end
            OP_INY: begin y = y + 8'd1; p = set_nz(p, y); end
            OP_DEY: begin y = y - 8'd1; p = set_nz(p, y); end
            OP_TAX: begin x = a; p = set_nz(p, x); end
            OP_TAY: begin y = a; p = set_nz(p, y); end
            OP_TXA: begin a = x; p = set_nz(p, a); end
            OP_TYA: begin a = y; p = set_nz(p, a); end
            OP_TSX: begin x = s; p = set_nz(p, x); end
            OP_TXS: s = x;
            OP_ANC: begin
                a = a & m;
                p = set_nz(p, a);
                p[FL_C] = a[7];
            end
            OP_ALR: begin
                t = a & m;
                a = {1'b0, t[7:1]};
                p[FL_C] = t[0];
                p = set_nz(p, a);
            end
            OP_ARR: begin
                t = a & m;
                a = {cin, t[7:1]};
                p[FL_C] = a[6];
                p[FL_V] = a[6] ^ a[5];
                p = set_nz(p, a);
            end
            OP_ANE: begin a = (a | ANE_MAGIC) & x & m; p = set_nz(p, a); end
            OP_LXA: begin a = (a | ANE_MAGIC) & m; x = a; p = set_nz(p, a); end
            OP_SBX: begin
                t = a & x;
                p[FL_C] = (t >= m);
                x = t - m;
                p = set_nz(p, x);
            end
            OP_LAS: begin a = s & m; x = a; s = a; p = set_nz(p, a); end
            OP_SLO: begin
                wv = {m[6:0], 1'b0};
                wr = 1'b1;
                p[FL_C] = m[7];
                a = a | wv;
                p = set_nz(p, a);
            end
            OP_RLA: begin
                wv = {m[6:0], cin};
                wr = 1'b1;
                p[FL_C] = m[7];
                a = a & wv;
                p = set_nz(p, a);
            end
            OP_SRE: begin
                wv = {1'b0, m[7:1]};
                wr = 1'b1;
                p[FL_C] = m[0];
                a = a ^ wv;
                p = set_nz(p, a);
            end
            OP_RRA: begin
                wv = {cin, m[7:1]};
                wr = 1'b1;
                p[FL_C] = m[0];
                ad = add_carry(p, a, wv);
                a  = ad.sum;
                p  = ad.p;
            end
            OP_DCP: begin
                wv = m - 8'd1;
                wr = 1'b1;
                p = compare(p, a, wv);
            end
            OP_ISB: begin
                wv = m + 8'd1;
                wr = 1'b1;
                ad = add_carry(p, a, ~wv);
                a  = ad.sum;
                p  = ad.p;
            end
            OP_SAX: begin wv = a & x; wr = 1'b1; end
            // Unused codes leave everything unchanged
            default: ;
        endcase

        res_word.acc_out   = a;
        res_word.x_out     = x;
        res_word.y_out     = y;
        res_word.sp_out    = s;
        res_word.flags_out = p;
        res_word.mem_value = wr ? wv : 8'h00;
        res_word.mem_write = wr;
    end

endmodule

`default_nettype wire

FILE: hdl/cpu_alu_with_illegal_ops_top.sv
// Top level of the 8-bit CPU ALU: input register, ALU datapath, result register.
// Depends on cpualu_pkg and cpualu_core.
//
//   port group | dir | handshake        | word
//   s_*        | in  | s_valid/s_ready  | s_data (in_t)
//   m_*        | out | m_valid/m_ready  | m_data (out_t)
//
// One word per cycle sustained when m_ready does not stall; an accepted word
// is held in the input register, then in the result register, from which it
// is taken on m_*.
// Reset (aresetn low, synchronous) empties both stages.
// A stall on m_ready holds the result register; the input register still
// takes one more word only if it is empty while the result waits.
`default_nettype none

module cpu_alu_with_illegal_ops_top
    import cpualu_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  wire  m_ready,
    output out_t m_data
);

    logic in_valid_reg;
    logic in_valid_next;
    in_t  in_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    out_t out_data_reg;
    out_t alu_res;
    logic adv;

    cpualu_core u_core (
        .op_word  (in_data_reg),
        .res_word (alu_res)
    );

    // Advance the input stage when the result register is free or draining
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture the input word, hold the result until taken
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv && in_valid_reg) begin
            out_data_reg <= alu_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/cpualu_checker.sv
// Port-level checks for cpu_alu_with_illegal_ops_top, attached by bind.
// Depends on cpualu_pkg.
`default_nettype none

module cpualu_checker
    import cpualu_pkg::*;
(
    input wire  aclk,
    input wire  aresetn,
    input wire  s_valid,
    input wire  s_ready,
    input wire  m_valid,
    input wire  m_ready,
    input out_t m_data
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    // No write-back byte without a write
    a_mem_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.mem_write |-> m_data.mem_value == 8'h00)
        else $error("mem_value nonzero without mem_write");

    // Backpressure only when a result waits
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with no waiting result");

    // An accepted word reaches the output when m_ready is high while it waits in the input register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready |=> m_valid)
        else $error("accepted word did not reach the output");

endmodule

bind cpu_alu_with_illegal_ops_top cpualu_checker u_checker (.*);

`default_nettype wire
